@@ hdl/bwt_pkg.sv @@
`default_nettype none

package bwt_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_ADD_BREAK   = 3'd0,
    CMD_ADD_WATCH   = 3'd1,
    CMD_REMOVE      = 3'd2,
    CMD_ENABLE      = 3'd3,
    CMD_DISABLE     = 3'd4,
    CMD_CHECK_EXEC  = 3'd5,
    CMD_CHECK_READ  = 3'd6,
    CMD_CHECK_WRITE = 3'd7
  } cmd_e;

  // breakpoint kinds
  localparam logic [1:0] BRK_PC      = 2'd0;
  localparam logic [1:0] BRK_CYCLE   = 2'd1;
  localparam logic [1:0] BRK_INSTRET = 2'd2;

  // watchpoint kinds
  localparam logic [1:0] WCH_READ  = 2'd0;
  localparam logic [1:0] WCH_WRITE = 2'd1;
  localparam logic [1:0] WCH_RW    = 2'd2;

  // one command beat
  typedef struct packed {
    cmd_e        command;
    logic [1:0]  kind;
    logic [63:0] break_value;
    logic [31:0] address;
    logic [31:0] size;
    logic [31:0] entry_id;
    logic [63:0] pc;
    logic [63:0] cycle;
    logic [63:0] instret;
  } bwt_item_t;

  // one result beat
  typedef struct packed {
    logic [31:0] assigned_id;
    logic        ok;
    logic        hit;
  } bwt_result_t;

endpackage

`default_nettype wire

@@ hdl/bwt_table.sv @@
`default_nettype none

module bwt_table #(
  parameter int unsigned BREAK_SLOTS = 8,
  parameter int unsigned WATCH_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bwt_pkg::bwt_item_t  item_i,
  output bwt_pkg::bwt_result_t result_o
);
  import bwt_pkg::*;

  localparam int unsigned BIW = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
  localparam int unsigned WIW = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;

  // table storage
  logic [BREAK_SLOTS-1:0] brk_valid_q;
  logic [31:0]            brk_id_q      [BREAK_SLOTS];
  logic [1:0]             brk_kind_q    [BREAK_SLOTS];
  logic [63:0]            brk_value_q   [BREAK_SLOTS];
  logic                   brk_enabled_q [BREAK_SLOTS];

  logic [WATCH_SLOTS-1:0] wch_valid_q;
  logic [31:0]            wch_id_q      [WATCH_SLOTS];
  logic [31:0]            wch_addr_q    [WATCH_SLOTS];
  logic [31:0]            wch_len_q     [WATCH_SLOTS];
  logic [1:0]             wch_kind_q    [WATCH_SLOTS];
  logic                   wch_enabled_q [WATCH_SLOTS];

  logic [31:0] id_counter_q;

  // lookup results
  logic           brk_free_found, wch_free_found;
  logic [BIW-1:0] brk_free_idx;
  logic [WIW-1:0] wch_free_idx;
  logic           brk_id_found, wch_id_found;
  logic [BIW-1:0] brk_id_idx;
  logic [WIW-1:0] wch_id_idx;
  logic [BREAK_SLOTS-1:0] brk_match;
  logic [WATCH_SLOTS-1:0] wch_match;
  logic [1:0]     own_kind;
  logic [31:0]    acc_end;

  // lowest free slot and lowest slot holding the id, per table
  always_comb begin
    brk_free_found = 1'b0;
    brk_free_idx   = '0;
    brk_id_found   = 1'b0;
    brk_id_idx     = '0;
    for (int i = BREAK_SLOTS - 1; i >= 0; i--) begin
      if (!brk_valid_q[i]) begin
        brk_free_found = 1'b1;
        brk_free_idx   = BIW'(i);
      end
      if (brk_valid_q[i] && (brk_id_q[i] == item_i.entry_id)) begin
        brk_id_found = 1'b1;
        brk_id_idx   = BIW'(i);
      end
    end
  end

  always_comb begin
    wch_free_found = 1'b0;
    wch_free_idx   = '0;
    wch_id_found   = 1'b0;
    wch_id_idx     = '0;
    for (int i = WATCH_SLOTS - 1; i >= 0; i--) begin
      if (!wch_valid_q[i]) begin
        wch_free_found = 1'b1;
        wch_free_idx   = WIW'(i);
      end
      if (wch_valid_q[i] && (wch_id_q[i] == item_i.entry_id)) begin
        wch_id_found = 1'b1;
        wch_id_idx   = WIW'(i);
      end
    end
  end

  // breakpoint compare per slot
  always_comb begin
    for (int i = 0; i < BREAK_SLOTS; i++) begin
      brk_match[i] = brk_valid_q[i] && brk_enabled_q[i] &&
                     (((brk_kind_q[i] == BRK_PC) && (item_i.pc == brk_value_q[i])) ||
                      ((brk_kind_q[i] == BRK_CYCLE) && (item_i.cycle >= brk_value_q[i])) ||
                      ((brk_kind_q[i] == BRK_INSTRET) &&
                       (item_i.instret >= brk_value_q[i])));
    end
  end

  // watchpoint range overlap per slot, sums wrap at 32 bits
  assign own_kind = (item_i.command == CMD_CHECK_READ) ? WCH_READ : WCH_WRITE;
  assign acc_end  = item_i.address + item_i.size;

  always_comb begin
    for (int i = 0; i < WATCH_SLOTS; i++) begin
      wch_match[i] = wch_valid_q[i] && wch_enabled_q[i] &&
                     ((wch_kind_q[i] == own_kind) || (wch_kind_q[i] == WCH_RW)) &&
                     (item_i.address < 32'(wch_addr_q[i] + wch_len_q[i])) &&
                     (wch_addr_q[i] < acc_end);
    end
  end

  // result of the current command
  always_comb begin
    result_o = '0;
    case (item_i.command)
      CMD_ADD_BREAK: begin
        result_o.ok          = brk_free_found;
        result_o.assigned_id = brk_free_found ? id_counter_q : '0;
      end
      CMD_ADD_WATCH: begin
        result_o.ok          = wch_free_found;
        result_o.assigned_id = wch_free_found ? id_counter_q : '0;
      end
      CMD_REMOVE, CMD_ENABLE, CMD_DISABLE: begin
        result_o.ok = brk_id_found || wch_id_found;
      end
      CMD_CHECK_EXEC: begin
        result_o.hit = |brk_match;
      end
      CMD_CHECK_READ, CMD_CHECK_WRITE: begin
        result_o.hit = |wch_match;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  // valid bits and id counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_valid_q  <= '0;
      wch_valid_q  <= '0;
      id_counter_q <= 32'd1;
    end else if (step_i) begin
      case (item_i.command)
        CMD_ADD_BREAK: begin
          if (brk_free_found) begin
            brk_valid_q[brk_free_idx] <= 1'b1;
            id_counter_q              <= id_counter_q + 32'd1;
          end
        end
        CMD_ADD_WATCH: begin
          if (wch_free_found) begin
            wch_valid_q[wch_free_idx] <= 1'b1;
            id_counter_q              <= id_counter_q + 32'd1;
          end
        end
        CMD_REMOVE: begin
          if (brk_id_found) begin
            brk_valid_q[brk_id_idx] <= 1'b0;
          end else if (wch_id_found) begin
            wch_valid_q[wch_id_idx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      case (item_i.command)
        CMD_ADD_BREAK: begin
          if (brk_free_found) begin
            brk_id_q[brk_free_idx]      <= id_counter_q;
            brk_kind_q[brk_free_idx]    <= item_i.kind;
            brk_value_q[brk_free_idx]   <= item_i.break_value;
            brk_enabled_q[brk_free_idx] <= 1'b1;
          end
        end
        CMD_ADD_WATCH: begin
          if (wch_free_found) begin
            wch_id_q[wch_free_idx]      <= id_counter_q;
            wch_addr_q[wch_free_idx]    <= item_i.address;
            wch_len_q[wch_free_idx]     <= item_i.size;
            wch_kind_q[wch_free_idx]    <= item_i.kind;
            wch_enabled_q[wch_free_idx] <= 1'b1;
          end
        end
        CMD_ENABLE, CMD_DISABLE: begin
          if (brk_id_found) begin
            brk_enabled_q[brk_id_idx] <= (item_i.command == CMD_ENABLE);
          end else if (wch_id_found) begin
            wch_enabled_q[wch_id_idx] <= (item_i.command == CMD_ENABLE);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/breakpoint_watchpoint_table_top.sv @@
`default_nettype none

// Debug trigger table: breakpoint and watchpoint slots with add, remove,
// enable, disable and check commands.
// Input channel: in_valid_i / in_stall_o carry one command beat in in_data_i.
// Output channel: out_valid_o / out_stall_i carry one result beat per command
// in out_data_o. A beat moves at a clock edge with valid high and stall low.
// Path: an accepted command goes into the input register, then through the
// table lookup and update into the result register.
// Throughput: one command per cycle while the receiver does not stall; the
// table lookup, update and all slot comparators are combinational between
// the two registers.
// When the receiver stalls, the result register holds its beat and the
// input register keeps taking one more command; with both full, in_stall_o
// rises until the result is taken.
// Reset empties both tables, sets the id counter to one and drops any beat
// in flight.
module breakpoint_watchpoint_table_top #(
  parameter int unsigned BREAK_SLOTS = 8,
  parameter int unsigned WATCH_SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bwt_pkg::bwt_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bwt_pkg::bwt_result_t out_data_o
);
  import bwt_pkg::*;

  logic        in_valid_q;
  bwt_item_t   in_item_q;
  logic        out_valid_q;
  bwt_result_t out_result_q;
  bwt_result_t result;
  logic        advance;
  logic        in_accept;

  // command moves into the table when the result register is empty or its beat is taken
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_data_i;
    end
  end

  // table lookup and update
  bwt_table #(
    .BREAK_SLOTS(BREAK_SLOTS),
    .WATCH_SLOTS(WATCH_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_item_q),
    .result_o(result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_result_q;

`ifndef ASSERT_OFF
  // input side only stalls while a finished result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // a command that enters the table always leaves a result beat
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("command entered the table but no result followed");

  // a hit comes only from a check, which never reports ok or an id
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |-> (!out_data_o.ok && (out_data_o.assigned_id == '0)))
    else $error("hit beat carries ok or an assigned id");

  // an assigned id implies a successful add
  a_id_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.assigned_id != '0)) |-> out_data_o.ok)
    else $error("assigned id without ok");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_breakpoint_watchpoint_table_top.sv @@
`timescale 1ns / 100ps

module tb_breakpoint_watchpoint_table_top;
  import bwt_pkg::*;

  localparam int BRK_N = 8;
  localparam int WCH_N = 8;
  localparam int RANDOM_PER_PHASE = 338;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  bwt_item_t   in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  bwt_result_t out_data_o;

  breakpoint_watchpoint_table_top #(
    .BREAK_SLOTS(BRK_N),
    .WATCH_SLOTS(WCH_N)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // shadow trigger tables
  logic        brk_live [BRK_N];
  logic [31:0] brk_ident[BRK_N];
  logic [1:0]  brk_kind [BRK_N];
  logic [63:0] brk_val  [BRK_N];
  logic        brk_armed[BRK_N];
  logic        wch_live [WCH_N];
  logic [31:0] wch_ident[WCH_N];
  logic [31:0] wch_base [WCH_N];
  logic [31:0] wch_len  [WCH_N];
  logic [1:0]  wch_kind [WCH_N];
  logic        wch_armed[WCH_N];
  logic [31:0] next_id;

  bwt_item_t   cmd_backlog[$];
  bwt_result_t result_due[$];
  bit          in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          mismatch_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_tables();
    int i;
    for (i = 0; i < BRK_N; i++) begin
      brk_live[i] = 1'b0;
      brk_ident[i] = '0;
      brk_kind[i] = '0;
      brk_val[i] = '0;
      brk_armed[i] = 1'b0;
    end
    for (i = 0; i < WCH_N; i++) begin
      wch_live[i] = 1'b0;
      wch_ident[i] = '0;
      wch_base[i] = '0;
      wch_len[i] = '0;
      wch_kind[i] = '0;
      wch_armed[i] = 1'b0;
    end
    next_id = 32'd1;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  // half-open ranges with 32-bit wrapping ends
  function automatic bit spans_overlap(input logic [31:0] a, input logic [31:0] as,
                                       input logic [31:0] b, input logic [31:0] bs);
    logic [31:0] a_end;
    logic [31:0] b_end;
    a_end = a + as;
    b_end = b + bs;
    return (a < b_end) && (b < a_end);
  endfunction

  // first match by id, breakpoints before watchpoints, lowest slot first
  function automatic bit act_on_entry(input cmd_e op, input logic [31:0] id);
    int i;
    for (i = 0; i < BRK_N; i++) begin
      if (brk_live[i] && brk_ident[i] == id) begin
        if (op == CMD_REMOVE) brk_live[i] = 1'b0;
        else brk_armed[i] = (op == CMD_ENABLE);
        return 1'b1;
      end
    end
    for (i = 0; i < WCH_N; i++) begin
      if (wch_live[i] && wch_ident[i] == id) begin
        if (op == CMD_REMOVE) wch_live[i] = 1'b0;
        else wch_armed[i] = (op == CMD_ENABLE);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // applies one command to the shadow tables and returns its result beat
  function automatic bwt_result_t predict_trigger(input bwt_item_t it);
    bwt_result_t r;
    logic [1:0]  want_kind;
    bit          placed;
    int          i;
    r = '0;
    placed = 1'b0;
    case (it.command)
      CMD_ADD_BREAK: begin
        for (i = 0; i < BRK_N; i++) begin
          if (!placed && !brk_live[i]) begin
            placed = 1'b1;
            brk_live[i] = 1'b1;
            brk_ident[i] = next_id;
            brk_kind[i] = it.kind;
            brk_val[i] = it.break_value;
            brk_armed[i] = 1'b1;
            r.assigned_id = next_id;
            r.ok = 1'b1;
            next_id = next_id + 32'd1;
          end
        end
      end
      CMD_ADD_WATCH: begin
        for (i = 0; i < WCH_N; i++) begin
          if (!placed && !wch_live[i]) begin
            placed = 1'b1;
            wch_live[i] = 1'b1;
            wch_ident[i] = next_id;
            wch_base[i] = it.address;
            wch_len[i] = it.size;
            wch_kind[i] = it.kind;
            wch_armed[i] = 1'b1;
            r.assigned_id = next_id;
            r.ok = 1'b1;
            next_id = next_id + 32'd1;
          end
        end
      end
      CMD_REMOVE, CMD_ENABLE, CMD_DISABLE: begin
        r.ok = act_on_entry(it.command, it.entry_id);
      end
      CMD_CHECK_EXEC: begin
        for (i = 0; i < BRK_N; i++) begin
          if (brk_live[i] && brk_armed[i]) begin
            if ((brk_kind[i] == BRK_PC && it.pc == brk_val[i]) ||
                (brk_kind[i] == BRK_CYCLE && it.cycle >= brk_val[i]) ||
                (brk_kind[i] == BRK_INSTRET && it.instret >= brk_val[i]))
              r.hit = 1'b1;
          end
        end
      end
      default: begin
        want_kind = (it.command == CMD_CHECK_READ) ? WCH_READ : WCH_WRITE;
        for (i = 0; i < WCH_N; i++) begin
          if (wch_live[i] && wch_armed[i] &&
              (wch_kind[i] == want_kind || wch_kind[i] == WCH_RW) &&
              spans_overlap(it.address, it.size, wch_base[i], wch_len[i]))
            r.hit = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic bwt_item_t random_item();
    bwt_item_t it;
    it.command = cmd_e'($urandom_range(0, 7));
    it.kind = 2'($urandom_range(0, 3));
    it.break_value = rand64();
    it.address = $urandom();
    it.size = $urandom();
    it.entry_id = $urandom();
    it.pc = rand64();
    it.cycle = rand64();
    it.instret = rand64();
    return it;
  endfunction

  // clustered addresses so that ranges actually meet, some near the wrap
  function automatic logic [31:0] near_address();
    case ($urandom_range(0, 3))
      0, 1: return 32'($urandom_range(0, 4095));
      2: return 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] short_size();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(1, 64));
    endcase
  endfunction

  // random command steered by the current shadow tables
  function automatic bwt_item_t next_random_command();
    bwt_item_t   it;
    logic [31:0] ids[$];
    logic [63:0] base;
    int          pick;
    int          i;
    it = random_item();
    pick = $urandom_range(0, 99);
    if (pick < 14) it.command = CMD_ADD_BREAK;
    else if (pick < 28) it.command = CMD_ADD_WATCH;
    else if (pick < 40) it.command = CMD_REMOVE;
    else if (pick < 48) it.command = CMD_ENABLE;
    else if (pick < 56) it.command = CMD_DISABLE;
    else if (pick < 72) it.command = CMD_CHECK_EXEC;
    else if (pick < 86) it.command = CMD_CHECK_READ;
    else it.command = CMD_CHECK_WRITE;
    case (it.command)
      CMD_ADD_BREAK: begin
        case ($urandom_range(0, 3))
          0: it.break_value = 64'($urandom_range(0, 2000));
          1: it.break_value = '1;
          2: it.break_value = '0;
          default: ;
        endcase
      end
      CMD_ADD_WATCH: begin
        it.address = near_address();
        it.size = short_size();
      end
      CMD_REMOVE, CMD_ENABLE, CMD_DISABLE: begin
        for (i = 0; i < BRK_N; i++) if (brk_live[i]) ids.push_back(brk_ident[i]);
        for (i = 0; i < WCH_N; i++) if (wch_live[i]) ids.push_back(wch_ident[i]);
        pick = $urandom_range(0, 9);
        if (ids.size() != 0 && pick < 8)
          it.entry_id = ids[$urandom_range(0, ids.size() - 1)];
        else if (pick == 8)
          it.entry_id = next_id - 32'($urandom_range(0, 4));
      end
      CMD_CHECK_EXEC: begin
        i = $urandom_range(0, BRK_N - 1);
        if (brk_live[i] && $urandom_range(0, 3) != 0) begin
          base = brk_val[i];
          if ($urandom_range(0, 1) == 1) it.pc = base;
          it.cycle = base - 64'd1 + 64'($urandom_range(0, 2));
          it.instret = base - 64'd1 + 64'($urandom_range(0, 2));
        end else if ($urandom_range(0, 1) == 1) begin
          it.cycle = 64'($urandom_range(0, 2000));
          it.instret = 64'($urandom_range(0, 2000));
        end
      end
      default: begin
        i = $urandom_range(0, WCH_N - 1);
        if (wch_live[i] && $urandom_range(0, 4) < 3)
          it.address = wch_base[i] + 32'($urandom_range(0, 8)) - 32'd4;
        else
          it.address = near_address();
        it.size = short_size();
      end
    endcase
    return it;
  endfunction

  task automatic queue_directed(input cmd_e c, input logic [1:0] k, input logic [63:0] v,
                                input logic [31:0] a, input logic [31:0] s,
                                input logic [31:0] id, input logic [63:0] cyc,
                                input logic [63:0] ret);
    bwt_item_t it;
    it = random_item();
    it.command = c;
    it.kind = k;
    it.break_value = v;
    it.pc = v;
    it.address = a;
    it.size = s;
    it.entry_id = id;
    it.cycle = cyc;
    it.instret = ret;
    cmd_backlog.push_back(it);
  endtask

  // command driver: a held beat stays put until it is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data_i <= cmd_backlog.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < stall_pct);
  end

  // monitor: check result beats, predict each accepted command beat
  always @(posedge clk_i) begin : monitor
    bwt_result_t want;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (result_due.size() == 0) begin
          report_mismatch("result with none pending", 64'(out_data_o), '0);
        end else begin
          want = result_due.pop_front();
          if (out_data_o.assigned_id !== want.assigned_id)
            report_mismatch("assigned_id", 64'(out_data_o.assigned_id), 64'(want.assigned_id));
          if (out_data_o.ok !== want.ok)
            report_mismatch("ok", 64'(out_data_o.ok), 64'(want.ok));
          if (out_data_o.hit !== want.hit)
            report_mismatch("hit", 64'(out_data_o.hit), 64'(want.hit));
        end
      end
      if (in_taken) result_due.push_back(predict_trigger(in_data_i));
    end
  end

  // stimulus
  initial begin
    int phase;
    int n;
    clear_tables();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty tables, then fill the breakpoint table past full
    queue_directed(CMD_CHECK_EXEC, 2'd0, '1, '0, '0, '0, '1, '1);
    queue_directed(CMD_CHECK_READ, 2'd0, '0, '0, '1, '0, '0, '0);
    queue_directed(CMD_ADD_BREAK, BRK_PC, '1, '0, '0, '0, '0, '0);
    queue_directed(CMD_ADD_BREAK, BRK_CYCLE, '0, '0, '0, '0, '0, '0);
    queue_directed(CMD_ADD_BREAK, BRK_INSTRET, 64'd1000, '0, '0, '0, '0, '0);
    queue_directed(CMD_ADD_BREAK, 2'd3, '0, '0, '0, '0, '0, '0);
    repeat (4) queue_directed(CMD_ADD_BREAK, BRK_PC, 64'd5, '0, '0, '0, '0, '0);
    queue_directed(CMD_ADD_BREAK, BRK_PC, '0, '0, '0, '0, '0, '0);
    queue_directed(CMD_CHECK_EXEC, 2'd0, '1, '0, '0, '0, '0, '0);
    queue_directed(CMD_DISABLE, 2'd0, '0, '0, '0, 32'd2, '0, '0);
    queue_directed(CMD_DISABLE, 2'd0, '0, '0, '0, 32'd1, '0, '0);
    queue_directed(CMD_CHECK_EXEC, 2'd0, '1, '0, '0, '0, '1, 64'd999);
    // unknown id, then remove a live id and enable it once removed
    queue_directed(CMD_REMOVE, 2'd0, '0, '0, '0, 32'd0, '0, '0);
    queue_directed(CMD_REMOVE, 2'd0, '0, '0, '0, 32'd3, '0, '0);
    queue_directed(CMD_ENABLE, 2'd0, '0, '0, '0, 32'd3, '0, '0);
    // wrapping range, zero length, full span, kind three
    queue_directed(CMD_ADD_WATCH, WCH_READ, '0, 32'hFFFF_FFF0, 32'h20, '0, '0, '0);
    queue_directed(CMD_ADD_WATCH, WCH_WRITE, '0, 32'h0, 32'h0, '0, '0, '0);
    queue_directed(CMD_ADD_WATCH, WCH_RW, '0, 32'h1000, '1, '0, '0, '0);
    queue_directed(CMD_ADD_WATCH, 2'd3, '0, 32'h0, '1, '0, '0, '0);
    queue_directed(CMD_CHECK_READ, 2'd0, '0, 32'hFFFF_FFF8, 32'd4, '0, '0, '0);
    queue_directed(CMD_CHECK_WRITE, 2'd0, '0, 32'h0, 32'h0, '0, '0, '0);
    queue_directed(CMD_CHECK_READ, 2'd0, '0, 32'h8, 32'h0, '0, '0, '0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // keep the backlog short so the shadow tables stay close to the block
        while (cmd_backlog.size() >= 4) @(posedge clk_i);
        cmd_backlog.push_back(next_random_command());
      end
    end

    while (cmd_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    stall_pct = 0;
    while (result_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (result_due.size() != 0)
      report_mismatch("results never arrived", 64'(result_due.size()), '0);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
hdl/bwt_pkg.sv
hdl/bwt_table.sv
hdl/breakpoint_watchpoint_table_top.sv
tb/sv/tb_breakpoint_watchpoint_table_top.sv
